### sv/tcce_pkg.sv
package tcce_pkg;

    // field widths
    localparam int COORD_W    = 12;
    localparam int COLOR_W    = 24;
    localparam int CODE_W     = 8;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // default cell geometry
    localparam int CHAR_WIDTH_DEF  = 8;
    localparam int CHAR_HEIGHT_DEF = 16;
    localparam int TAB_CELLS_DEF   = 8;

    // result queue depth, must be a power of two and at least two
    localparam int QUEUE_DEPTH = 4;

    // command codes
    localparam logic [CMD_W-1:0] CMD_GLYPH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SCROLL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // input modes
    localparam logic MODE_CHAR  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // console byte codes with special handling
    localparam logic [CODE_W-1:0] CHR_NUL   = 8'h00;
    localparam logic [CODE_W-1:0] CHR_BS    = 8'h08;
    localparam logic [CODE_W-1:0] CHR_TAB   = 8'h09;
    localparam logic [CODE_W-1:0] CHR_LF    = 8'h0A;
    localparam logic [CODE_W-1:0] CHR_CR    = 8'h0D;
    localparam logic [CODE_W-1:0] CHR_SPACE = 8'h20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_EDGE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_EDGE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_EDGE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_EDGE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR  = 3'd6;

    // configuration reset values
    localparam logic [COORD_W-1:0] RIGHT_EDGE_RST  = 12'd960;
    localparam logic [COORD_W-1:0] BOTTOM_EDGE_RST = 12'd768;
    localparam logic [COLOR_W-1:0] FORE_COLOR_RST  = 24'h00FFC0;

    // one drawing command
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic [COORD_W-1:0] glyph_x;
        logic [COORD_W-1:0] glyph_y;
        logic [COLOR_W-1:0] color_fore;
        logic [COLOR_W-1:0] color_back;
        logic               last;
    } result_t;

endpackage

### sv/text_console_cursor_engine_top.sv
// Text console cursor engine: turns console bytes into drawing commands.
// Input channel: in_valid / in_stall with mode and char_code. A transaction
// is taken at a rising edge with in_valid high and in_stall low. Mode 1
// clears the console and homes the cursor; mode 0 handles one byte.
// Output channel: out_valid / out_stall with one drawing command per
// transaction; last marks the final command caused by one input byte.
// Each byte is decoded and the cursor updated in the cycle it is taken;
// its zero, one or two commands are registered in a four-entry result
// queue, whose head command drives the outputs.
// Throughput is one byte per cycle while the queue holds at most two
// commands; in_stall rises when three or more wait, so the sustained rate
// is set by how fast the receiver drains commands (a byte giving glyph
// plus scroll puts two commands in the queue).
// The configuration port writes one register per cycle on cfg_write; write
// it only while no commands are pending.
// Reset clears the queue, homes the cursor to pixel 0,0 and loads the
// register defaults (console disabled). A stall on the output holds the
// head command steady; the queue absorbs new bytes until in_stall rises.
module text_console_cursor_engine_top #(
    parameter int CHAR_WIDTH  = tcce_pkg::CHAR_WIDTH_DEF,
    parameter int CHAR_HEIGHT = tcce_pkg::CHAR_HEIGHT_DEF,
    parameter int TAB_CELLS   = tcce_pkg::TAB_CELLS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration port
    input  logic                                 cfg_write,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 mode,
    input  logic [tcce_pkg::CODE_W-1:0]          char_code,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tcce_pkg::CMD_W-1:0]           command,
    output logic [tcce_pkg::COORD_W-1:0]         dest_x,
    output logic [tcce_pkg::COORD_W-1:0]         dest_y,
    output logic [tcce_pkg::COORD_W-1:0]         glyph_x,
    output logic [tcce_pkg::COORD_W-1:0]         glyph_y,
    output logic [tcce_pkg::COLOR_W-1:0]         color_fore,
    output logic [tcce_pkg::COLOR_W-1:0]         color_back,
    output logic                                 last
);

    localparam int CW     = tcce_pkg::COORD_W;
    localparam int KW     = tcce_pkg::COLOR_W;
    localparam int TAB_PX = TAB_CELLS * CHAR_WIDTH;
    localparam int MAX_PX = (TAB_PX > 2 * CHAR_HEIGHT) ? TAB_PX : 2 * CHAR_HEIGHT;
    localparam int STEP_W = $clog2(MAX_PX + 1);
    localparam int SUM_W  = ((STEP_W > CW) ? STEP_W : CW) + 1;
    localparam int DEPTH  = tcce_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [SUM_W-1:0] W_E   = SUM_W'(CHAR_WIDTH);
    localparam logic [SUM_W-1:0] H_E   = SUM_W'(CHAR_HEIGHT);
    localparam logic [SUM_W-1:0] TAB_E = SUM_W'(TAB_PX);
    localparam logic [CW-1:0]    W_C   = CW'(CHAR_WIDTH);
    localparam logic [CW-1:0]    H_C   = CW'(CHAR_HEIGHT);

    // configuration registers
    logic            enable_reg;
    logic [CW-1:0]   left_edge_reg;
    logic [CW-1:0]   top_edge_reg;
    logic [CW-1:0]   right_edge_reg;
    logic [CW-1:0]   bottom_edge_reg;
    logic [KW-1:0]   fore_color_reg;
    logic [KW-1:0]   back_color_reg;

    // cursor state
    logic [CW-1:0]   cursor_x_reg;
    logic [CW-1:0]   cursor_y_reg;
    logic [CW-1:0]   cursor_x_next;
    logic [CW-1:0]   cursor_y_next;

    // result queue
    tcce_pkg::result_t queue_reg [DEPTH];
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  tail_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  head_next;
    logic [PTR_W-1:0]  tail_next;
    logic [CNT_W-1:0]  count_next;
    logic [PTR_W-1:0]  tail_plus;

    logic              accept;
    logic              pop;
    logic [1:0]        push_n;
    tcce_pkg::result_t res0;
    tcce_pkg::result_t res1;
    tcce_pkg::result_t head_entry;

    // decode temporaries
    logic [SUM_W-1:0]  cx_e;
    logic [SUM_W-1:0]  cy_e;
    logic [SUM_W-1:0]  y_step;
    logic              row_scroll;
    logic [CW-1:0]     row_y;
    logic [SUM_W-1:0]  x_char;
    logic [SUM_W-1:0]  x_tab;
    logic              wrap_char;
    logic              wrap_tab;
    logic [CW-1:0]     bs_end_x;
    logic [tcce_pkg::CODE_W-1:0] glyph_code;
    logic              has_prim;
    logic              has_scroll;
    tcce_pkg::result_t prim_res;
    tcce_pkg::result_t scroll_res;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (count_reg > CNT_W'(DEPTH - 2));
    assign pop      = out_valid && !out_stall;
    assign tail_plus = tail_reg + PTR_W'(1);

    // shared cursor arithmetic: row advance, right moves, backspace target, glyph code
    always_comb
    begin
        cx_e       = SUM_W'(cursor_x_reg);
        cy_e       = SUM_W'(cursor_y_reg);
        y_step     = cy_e + H_E;
        row_scroll = (y_step + H_E) > SUM_W'(bottom_edge_reg);
        if (row_scroll)
        begin
            row_y = (bottom_edge_reg >= H_C) ? (bottom_edge_reg - H_C) : '0;
        end
        else
        begin
            row_y = y_step[CW-1:0];
        end
        x_char    = cx_e + W_E;
        x_tab     = cx_e + TAB_E;
        wrap_char = x_char > SUM_W'(right_edge_reg);
        wrap_tab  = x_tab > SUM_W'(right_edge_reg);
        bs_end_x  = (right_edge_reg >= W_C) ? (right_edge_reg - W_C) : '0;
        glyph_code = (char_code <= tcce_pkg::CHR_SPACE) ? tcce_pkg::CHR_SPACE : char_code;
    end

    // byte decode: next cursor and the commands produced
    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        has_prim      = 1'b0;
        has_scroll    = 1'b0;

        prim_res            = '0;
        prim_res.color_back = back_color_reg;
        scroll_res            = '0;
        scroll_res.command    = tcce_pkg::CMD_SCROLL;
        scroll_res.color_back = back_color_reg;
        scroll_res.last       = 1'b1;

        if (enable_reg)
        begin
            if (mode == tcce_pkg::MODE_CLEAR)
            begin
                has_prim         = 1'b1;
                prim_res.command = tcce_pkg::CMD_CLEAR;
                cursor_x_next    = left_edge_reg;
                cursor_y_next    = top_edge_reg;
            end
            else
            begin
                case (char_code)
                    tcce_pkg::CHR_NUL:
                    begin
                        has_prim = 1'b0;
                    end
                    tcce_pkg::CHR_CR:
                    begin
                        cursor_x_next = left_edge_reg;
                    end
                    tcce_pkg::CHR_LF:
                    begin
                        cursor_y_next = row_y;
                        has_scroll    = row_scroll;
                    end
                    tcce_pkg::CHR_BS:
                    begin
                        if (cx_e >= SUM_W'(left_edge_reg) + W_E)
                        begin
                            cursor_x_next = cursor_x_reg - W_C;
                        end
                        else if (cy_e >= SUM_W'(top_edge_reg) + H_E)
                        begin
                            cursor_x_next = bs_end_x;
                            cursor_y_next = cursor_y_reg - H_C;
                        end
                    end
                    tcce_pkg::CHR_TAB:
                    begin
                        if (wrap_tab)
                        begin
                            cursor_x_next = left_edge_reg;
                            cursor_y_next = row_y;
                            has_scroll    = row_scroll;
                        end
                        else
                        begin
                            cursor_x_next = x_tab[CW-1:0];
                        end
                    end
                    default:
                    begin
                        has_prim            = 1'b1;
                        prim_res.command    = tcce_pkg::CMD_GLYPH;
                        prim_res.dest_x     = cursor_x_reg;
                        prim_res.dest_y     = cursor_y_reg;
                        prim_res.glyph_x    = CW'(glyph_code[7:5]) * W_C;
                        prim_res.glyph_y    = CW'(glyph_code[4:0]) * H_C;
                        prim_res.color_fore = fore_color_reg;
                        if (wrap_char)
                        begin
                            cursor_x_next = left_edge_reg;
                            cursor_y_next = row_y;
                            has_scroll    = row_scroll;
                        end
                        else
                        begin
                            cursor_x_next = x_char[CW-1:0];
                        end
                    end
                endcase
            end
        end

        prim_res.last = !has_scroll;
        res0   = has_prim ? prim_res : scroll_res;
        res1   = scroll_res;
        push_n = {1'b0, has_prim} + {1'b0, has_scroll};
    end

    // queue pointers
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop)
        begin
            head_next = head_reg + PTR_W'(1);
        end
        if (accept)
        begin
            tail_next = tail_reg + PTR_W'(push_n);
        end
        count_next = count_reg + (accept ? CNT_W'(push_n) : '0) - CNT_W'(pop);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            left_edge_reg   <= '0;
            top_edge_reg    <= '0;
            right_edge_reg  <= tcce_pkg::RIGHT_EDGE_RST;
            bottom_edge_reg <= tcce_pkg::BOTTOM_EDGE_RST;
            fore_color_reg  <= tcce_pkg::FORE_COLOR_RST;
            back_color_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tcce_pkg::REG_ENABLE:      enable_reg      <= cfg_data[0];
                tcce_pkg::REG_LEFT_EDGE:   left_edge_reg   <= cfg_data[CW-1:0];
                tcce_pkg::REG_TOP_EDGE:    top_edge_reg    <= cfg_data[CW-1:0];
                tcce_pkg::REG_RIGHT_EDGE:  right_edge_reg  <= cfg_data[CW-1:0];
                tcce_pkg::REG_BOTTOM_EDGE: bottom_edge_reg <= cfg_data[CW-1:0];
                tcce_pkg::REG_FORE_COLOR:  fore_color_reg  <= cfg_data[KW-1:0];
                tcce_pkg::REG_BACK_COLOR:  back_color_reg  <= cfg_data[KW-1:0];
                default:
                begin
                    enable_reg <= enable_reg;
                end
            endcase
        end
    end

    // cursor and queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                cursor_x_reg <= cursor_x_next;
                cursor_y_reg <= cursor_y_next;
            end
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (accept && (push_n != 2'd0))
        begin
            queue_reg[tail_reg] <= res0;
        end
        if (accept && (push_n == 2'd2))
        begin
            queue_reg[tail_plus] <= res1;
        end
    end

    // output channel
    assign head_entry = queue_reg[head_reg];
    assign out_valid  = (count_reg != '0);
    assign command    = head_entry.command;
    assign dest_x     = head_entry.dest_x;
    assign dest_y     = head_entry.dest_y;
    assign glyph_x    = head_entry.glyph_x;
    assign glyph_y    = head_entry.glyph_y;
    assign color_fore = head_entry.color_fore;
    assign color_back = head_entry.color_back;
    assign last       = head_entry.last;

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    // a byte is only taken when room remains for two commands
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (count_reg <= CNT_W'(DEPTH - 2)))
        else $error("byte taken without room for its commands");

    // a disabled console leaves the cursor alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !enable_reg) |=> ($stable(cursor_x_reg) && $stable(cursor_y_reg)))
        else $error("cursor moved while console disabled");

    // a disabled console queues nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !enable_reg) |=> (count_reg == $past(count_reg) - CNT_W'($past(pop))))
        else $error("command queued while console disabled");

    // a scroll always closes the commands of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (command == tcce_pkg::CMD_SCROLL)) |-> last)
        else $error("scroll command not marked last");

endmodule

### bench/text_console_draw_checker.sv
`timescale 1ns / 1ps

module text_console_draw_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                mode,
    input  logic [tcce_pkg::CODE_W-1:0]         char_code,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [tcce_pkg::CMD_W-1:0]          command,
    input  logic [tcce_pkg::COORD_W-1:0]        dest_x,
    input  logic [tcce_pkg::COORD_W-1:0]        dest_y,
    input  logic [tcce_pkg::COORD_W-1:0]        glyph_x,
    input  logic [tcce_pkg::COORD_W-1:0]        glyph_y,
    input  logic [tcce_pkg::COLOR_W-1:0]        color_fore,
    input  logic [tcce_pkg::COLOR_W-1:0]        color_back,
    input  logic                                last,
    output int                                  fail_count,
    output int                                  outstanding
);

    localparam int CW   = tcce_pkg::CHAR_WIDTH_DEF;
    localparam int CH   = tcce_pkg::CHAR_HEIGHT_DEF;
    localparam int TABS = tcce_pkg::TAB_CELLS_DEF;
    localparam int XW   = tcce_pkg::COORD_W;
    localparam int KW   = tcce_pkg::COLOR_W;

    // shadow of the console registers and the cursor
    logic          en_q     = 1'b0;
    logic [XW-1:0] left_q   = '0;
    logic [XW-1:0] top_q    = '0;
    logic [XW-1:0] right_q  = tcce_pkg::RIGHT_EDGE_RST;
    logic [XW-1:0] bottom_q = tcce_pkg::BOTTOM_EDGE_RST;
    logic [KW-1:0] fore_q   = tcce_pkg::FORE_COLOR_RST;
    logic [KW-1:0] back_q   = '0;
    logic [XW-1:0] cur_x    = '0;
    logic [XW-1:0] cur_y    = '0;

    // draw commands still owed by the block, oldest first
    tcce_pkg::result_t expected_draws[$];
    int                fails = 0;

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic string describe(tcce_pkg::result_t d);
        return $sformatf("cmd=%0d dest=(%0d,%0d) glyph=(%0d,%0d) fore=%06h back=%06h last=%0b",
                         d.command, d.dest_x, d.dest_y, d.glyph_x, d.glyph_y,
                         d.color_fore, d.color_back, d.last);
    endfunction

    function automatic tcce_pkg::result_t make_draw(logic [tcce_pkg::CMD_W-1:0] cmd,
                                                    logic [XW-1:0] dx, logic [XW-1:0] dy,
                                                    logic [XW-1:0] gx, logic [XW-1:0] gy,
                                                    logic [KW-1:0] fc);
        tcce_pkg::result_t d;
        d.command    = cmd;
        d.dest_x     = dx;
        d.dest_y     = dy;
        d.glyph_x    = gx;
        d.glyph_y    = gy;
        d.color_fore = fc;
        d.color_back = back_q;
        d.last       = 1'b0;
        return d;
    endfunction

    // one row down, clamped at the bottom; true when the area must scroll
    function automatic bit advance_row();
        int y;
        bit scroll;
        y = cur_y + CH;
        scroll = 1'b0;
        if (y + CH > bottom_q)
        begin
            y = (bottom_q >= CH) ? bottom_q - CH : 0;
            scroll = 1'b1;
        end
        cur_y = y[XW-1:0];
        return scroll;
    endfunction

    // move right with wrap past the right edge
    function automatic bit step_right(int px);
        int x;
        x = cur_x + px;
        if (x > right_q)
        begin
            cur_x = left_q;
            return advance_row();
        end
        cur_x = x[XW-1:0];
        return 1'b0;
    endfunction

    // works out the commands one accepted byte causes and queues them
    function automatic void predict_byte(logic m, logic [tcce_pkg::CODE_W-1:0] c);
        tcce_pkg::result_t batch[$];
        bit                scroll;
        logic [7:0]        g;
        scroll = 1'b0;
        if (!en_q)
            return;
        if (m == tcce_pkg::MODE_CLEAR)
        begin
            batch.push_back(make_draw(tcce_pkg::CMD_CLEAR, '0, '0, '0, '0, '0));
            cur_x = left_q;
            cur_y = top_q;
        end
        else
        begin
            case (c)
                tcce_pkg::CHR_NUL: ;
                tcce_pkg::CHR_CR:  cur_x = left_q;
                tcce_pkg::CHR_LF:  scroll = advance_row();
                tcce_pkg::CHR_BS:
                begin
                    if (cur_x >= left_q + CW)
                        cur_x = XW'(cur_x - CW);
                    else if (cur_y >= top_q + CH)
                    begin
                        cur_x = (right_q >= CW) ? XW'(right_q - CW) : '0;
                        cur_y = XW'(cur_y - CH);
                    end
                end
                tcce_pkg::CHR_TAB: scroll = step_right(CW * TABS);
                default:
                begin
                    g = (c <= tcce_pkg::CHR_SPACE) ? tcce_pkg::CHR_SPACE : c;
                    batch.push_back(make_draw(tcce_pkg::CMD_GLYPH, cur_x, cur_y,
                                              XW'(CW * g[7:5]), XW'(CH * g[4:0]), fore_q));
                    scroll = step_right(CW);
                end
            endcase
            if (scroll)
                batch.push_back(make_draw(tcce_pkg::CMD_SCROLL, '0, '0, '0, '0, '0));
        end
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[i])
            expected_draws.push_back(batch[i]);
    endfunction

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin : watch
        tcce_pkg::result_t seen;
        tcce_pkg::result_t want;
        if (!rst_n)
        begin
            en_q     = 1'b0;
            left_q   = '0;
            top_q    = '0;
            right_q  = tcce_pkg::RIGHT_EDGE_RST;
            bottom_q = tcce_pkg::BOTTOM_EDGE_RST;
            fore_q   = tcce_pkg::FORE_COLOR_RST;
            back_q   = '0;
            cur_x    = '0;
            cur_y    = '0;
            expected_draws.delete();
        end
        else
        begin
            // output transaction against the oldest expectation
            if (out_valid && !out_stall)
            begin
                seen = {command, dest_x, dest_y, glyph_x, glyph_y,
                        color_fore, color_back, last};
                if (expected_draws.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected draw command: %s", describe(seen));
                end
                else
                begin
                    want = expected_draws.pop_front();
                    if (seen !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $display("draw command mismatch at %0t", $realtime);
                            $display("  expected %s", describe(want));
                            $display("  actual   %s", describe(seen));
                        end
                    end
                end
            end
            // register writes
            if (cfg_write)
            begin
                case (cfg_index)
                    tcce_pkg::REG_ENABLE:      en_q     = cfg_data[0];
                    tcce_pkg::REG_LEFT_EDGE:   left_q   = cfg_data[XW-1:0];
                    tcce_pkg::REG_TOP_EDGE:    top_q    = cfg_data[XW-1:0];
                    tcce_pkg::REG_RIGHT_EDGE:  right_q  = cfg_data[XW-1:0];
                    tcce_pkg::REG_BOTTOM_EDGE: bottom_q = cfg_data[XW-1:0];
                    tcce_pkg::REG_FORE_COLOR:  fore_q   = cfg_data[KW-1:0];
                    tcce_pkg::REG_BACK_COLOR:  back_q   = cfg_data[KW-1:0];
                    default: ;
                endcase
            end
            // input transaction
            if (in_valid && !in_stall)
                predict_byte(mode, char_code);
        end
        outstanding <= expected_draws.size();
        fail_count  <= fails;
    end

endmodule

### bench/text_console_cursor_engine_top_test.sv
`timescale 1ns / 1ps

module text_console_cursor_engine_top_test;

    localparam int XW = tcce_pkg::COORD_W;
    localparam int KW = tcce_pkg::COLOR_W;
    localparam int BW = tcce_pkg::CODE_W;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                cfg_write;
    logic [tcce_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [tcce_pkg::CFG_DATA_W-1:0]     cfg_data;
    logic                                in_valid;
    logic                                in_stall;
    logic                                mode;
    logic [BW-1:0]                       char_code;
    logic                                out_valid;
    logic                                out_stall;
    logic [tcce_pkg::CMD_W-1:0]          command;
    logic [XW-1:0]                       dest_x;
    logic [XW-1:0]                       dest_y;
    logic [XW-1:0]                       glyph_x;
    logic [XW-1:0]                       glyph_y;
    logic [KW-1:0]                       color_fore;
    logic [KW-1:0]                       color_back;
    logic                                last;
    int                                  fail_count;
    int                                  outstanding;

    bit gaps_on  = 1'b0;
    bit stall_on = 1'b0;

    text_console_cursor_engine_top DUT (.*);

    text_console_draw_checker draw_check (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // overall time limit
    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // receiver back-pressure in random bursts
    initial
    begin : stall_gen
        int hold;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!stall_on)
            begin
                hold = 0;
                out_stall <= 1'b0;
            end
            else if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(0, 13);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // one input transaction, with an optional gap before it; valid stays high
    task automatic send_byte(input logic m, input logic [BW-1:0] c);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        char_code <= c;
        do @(posedge clk); while (in_stall);
    endtask

    // stop sending and wait until every owed command has come out
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    // write all seven registers while the block is idle
    task automatic configure(input logic en, input logic [XW-1:0] l, t, r, b,
                             input logic [KW-1:0] fc, bc);
        logic [tcce_pkg::CFG_DATA_W-1:0] vals[7];
        vals[tcce_pkg::REG_ENABLE]      = {23'd0, en};
        vals[tcce_pkg::REG_LEFT_EDGE]   = {12'd0, l};
        vals[tcce_pkg::REG_TOP_EDGE]    = {12'd0, t};
        vals[tcce_pkg::REG_RIGHT_EDGE]  = {12'd0, r};
        vals[tcce_pkg::REG_BOTTOM_EDGE] = {12'd0, b};
        vals[tcce_pkg::REG_FORE_COLOR]  = fc;
        vals[tcce_pkg::REG_BACK_COLOR]  = bc;
        for (int i = tcce_pkg::REG_ENABLE; i <= tcce_pkg::REG_BACK_COLOR; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= i[tcce_pkg::CFG_IDX_W-1:0];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    // random bytes weighted towards printable text and cursor controls
    task automatic send_random(input int count);
        int            r;
        logic          m;
        logic [BW-1:0] c;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            m = tcce_pkg::MODE_CHAR;
            c = BW'($urandom_range(0, 255));
            if (r < 3)
                m = tcce_pkg::MODE_CLEAR;
            else if (r < 38)
                c = BW'($urandom_range(8'h21, 8'hFF));
            else if (r < 48)
                c = BW'($urandom_range(8'h01, 8'h20));
            else if (r < 58)
                c = tcce_pkg::CHR_CR;
            else if (r < 70)
                c = tcce_pkg::CHR_LF;
            else if (r < 80)
                c = tcce_pkg::CHR_BS;
            else if (r < 88)
                c = tcce_pkg::CHR_TAB;
            else if (r < 91)
                c = tcce_pkg::CHR_NUL;
            send_byte(m, c);
        end
    endtask

    // small console area so that wraps and scrolls come often
    task automatic small_area_phase(input int count);
        logic [XW-1:0] l;
        logic [XW-1:0] t;
        l = XW'($urandom_range(0, 300));
        t = XW'($urandom_range(0, 300));
        configure(1'b1, l, t, l + XW'($urandom_range(0, 100)),
                  t + XW'($urandom_range(16, 80)),
                  KW'($urandom_range(0, 24'hFFFFFF)), KW'($urandom_range(0, 24'hFFFFFF)));
        send_random(count);
        drain();
    endtask

    initial
    begin : stimulus
        logic [8:0] script[20];
        script = '{{tcce_pkg::MODE_CLEAR, 8'hFF}, {tcce_pkg::MODE_CHAR, tcce_pkg::CHR_NUL},
                   {tcce_pkg::MODE_CHAR, 8'h41}, {tcce_pkg::MODE_CHAR, 8'hFF},
                   {tcce_pkg::MODE_CHAR, 8'h01}, {tcce_pkg::MODE_CHAR, tcce_pkg::CHR_SPACE},
                   {tcce_pkg::MODE_CHAR, 8'h7F}, {tcce_pkg::MODE_CHAR, 8'h80},
                   {tcce_pkg::MODE_CHAR, tcce_pkg::CHR_BS},
                   {tcce_pkg::MODE_CHAR, tcce_pkg::CHR_BS},
                   {tcce_pkg::MODE_CHAR, tcce_pkg::CHR_CR},
                   {tcce_pkg::MODE_CHAR, tcce_pkg::CHR_BS},
                   {tcce_pkg::MODE_CHAR, tcce_pkg::CHR_LF},
                   {tcce_pkg::MODE_CHAR, tcce_pkg::CHR_LF},
                   {tcce_pkg::MODE_CHAR, tcce_pkg::CHR_TAB},
                   {tcce_pkg::MODE_CHAR, 8'h1F}, {tcce_pkg::MODE_CHAR, 8'h7E},
                   {tcce_pkg::MODE_CHAR, tcce_pkg::CHR_CR},
                   {tcce_pkg::MODE_CHAR, tcce_pkg::CHR_TAB},
                   {tcce_pkg::MODE_CLEAR, tcce_pkg::CHR_NUL}};

        // reset with every input at a known value
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= tcce_pkg::REG_ENABLE;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        mode      <= tcce_pkg::MODE_CHAR;
        char_code <= tcce_pkg::CHR_NUL;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // console is off after reset, so these give nothing
        stall_on = 1'b1;
        send_byte(tcce_pkg::MODE_CHAR, 8'h41);
        send_byte(tcce_pkg::MODE_CLEAR, 8'h41);
        drain();

        // directed bytes in a 40 by 40 pixel area: glyphs, controls, wrap, scroll
        configure(1'b1, 12'd0, 12'd0, 12'd40, 12'd40, 24'hFFFFFF, 24'h000000);
        foreach (script[i])
            send_byte(script[i][8], script[i][7:0]);
        drain();

        // full-size console with random colours
        gaps_on = 1'b1;
        configure(1'b1, 12'd0, 12'd0, 12'd960, 12'd768,
                  KW'($urandom_range(0, 24'hFFFFFF)), KW'($urandom_range(0, 24'hFFFFFF)));
        send_random(150);
        drain();

        small_area_phase(150);

        // every edge at its maximum
        configure(1'b1, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_random(100);
        drain();

        // every edge at zero, so the row and column clamps engage
        configure(1'b1, 12'd0, 12'd0, 12'd0, 12'd0, 24'h000000, 24'h000000);
        send_random(100);
        drain();

        // disabled again: bytes are ignored
        configure(1'b0, 12'd8, 12'd16, 12'd200, 12'd200, 24'h123456, 24'hABCDEF);
        send_random(20);
        drain();

        // fully random edges
        configure(1'b1, XW'($urandom_range(0, 12'hFFF)), XW'($urandom_range(0, 12'hFFF)),
                  XW'($urandom_range(0, 12'hFFF)), XW'($urandom_range(0, 12'hFFF)),
                  KW'($urandom_range(0, 24'hFFFFFF)), KW'($urandom_range(0, 24'hFFFFFF)));
        send_random(150);
        drain();

        small_area_phase(200);

        // last stretch at full rate, no gaps and no back-pressure
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        small_area_phase(200);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
